// ===== sv/gpa_cipher_keystream_core_macros.svh =====
// Assertion macros for the GPA keystream core.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef GPA_CIPHER_KEYSTREAM_CORE_MACROS_SVH
`define GPA_CIPHER_KEYSTREAM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gpa_ks_pkg.sv =====
// Shared types and constants of the GPA keystream core.
// No dependencies; used by the interfaces, controller, datapath and top level.
package gpa_ks_pkg;

  localparam int unsigned RW = 5;   // R cell width
  localparam int unsigned SW = 7;   // S cell width
  localparam int unsigned TW = 5;   // T cell width
  localparam int unsigned RN = 7;   // R cell count
  localparam int unsigned SN = 7;   // S cell count
  localparam int unsigned TN = 5;   // T cell count
  localparam int unsigned CNT_W = 4;

  typedef enum logic {
    CMD_CLOCK = 1'b0,
    CMD_CLEAR = 1'b1
  } gpa_cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } gpa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the data byte of a clock beat
    logic clear;     // zero all cipher state
    logic step;      // apply one cipher step
    logic res_load;  // capture the output byte as the result
  } dp_cmd_t;

endpackage

// ===== sv/gpa_ks_if.sv =====
// Handshake channels of the GPA keystream core: command input and result output.
// Depends on gpa_ks_pkg for field widths.
interface gpa_ks_in_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [7:0]                      data_in;
  logic [gpa_ks_pkg::CNT_W-1:0]    repeat_count;

  modport source (output valid, command, data_in, repeat_count, input ready);
  modport sink   (input valid, command, data_in, repeat_count, output ready);
endinterface

interface gpa_ks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ks_byte;

  modport source (output valid, ks_byte, input ready);
  modport sink   (input valid, ks_byte, output ready);
endinterface

// ===== sv/gpa_ks_ctrl.sv =====
// Controller of the GPA keystream core: step sequencing and both handshakes.
// Depends on gpa_ks_pkg.
module gpa_ks_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_command_i,
  input  logic [gpa_ks_pkg::CNT_W-1:0]  in_count_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gpa_ks_pkg::dp_cmd_t           cmd_o
);

  gpa_ks_pkg::gpa_state_e          state_q, state_d;
  logic [gpa_ks_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                            ovalid_q, ovalid_d;
  logic                            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gpa_ks_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == gpa_ks_pkg::ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      gpa_ks_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = gpa_ks_pkg::ST_RUN;
          if (in_command_i == gpa_ks_pkg::CMD_CLEAR) begin
            cmd_o.clear = 1'b1;
            cnt_d       = '0;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = in_count_i;
          end
        end
      end
      gpa_ks_pkg::ST_RUN: begin
        if (cnt_q != '0) begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q - 1'b1;
        end else if (!ovalid_q || out_ready_i) begin
          // Result slot is free (or drains this cycle): publish and finish.
          cmd_o.res_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = gpa_ks_pkg::ST_IDLE;
        end
      end
      default: state_d = gpa_ks_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/gpa_ks_dp.sv =====
// Datapath of the GPA keystream core: the R, S and T shift registers,
// the output byte and the result register. Depends on gpa_ks_pkg.
module gpa_ks_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpa_ks_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]           data_in_i,
  output logic [7:0]           ks_byte_o
);

  localparam int unsigned RW = gpa_ks_pkg::RW;
  localparam int unsigned SW = gpa_ks_pkg::SW;
  localparam int unsigned TW = gpa_ks_pkg::TW;
  localparam int unsigned RN = gpa_ks_pkg::RN;
  localparam int unsigned SN = gpa_ks_pkg::SN;
  localparam int unsigned TN = gpa_ks_pkg::TN;

  logic [RW-1:0] r_q [RN];
  logic [RW-1:0] r_d [RN];
  logic [SW-1:0] s_q [SN];
  logic [SW-1:0] s_d [SN];
  logic [TW-1:0] t_q [TN];
  logic [TW-1:0] t_d [TN];
  logic [7:0]    ob_q, ob_d;
  logic [7:0]    din_q;
  logic [7:0]    res_q;

  logic [7:0]    mix;
  logic [RW-1:0] ri, r_rot, r_head;
  logic [SW-1:0] si, s_rot, s_head;
  logic [TW-1:0] ti, t_head;
  logic [3:0]    nib;

  // End-around-carry addition modulo 31 on 5-bit operands.
  function automatic logic [4:0] add31(logic [4:0] a, logic [4:0] b);
    logic [5:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum > 6'd31) sum = sum - 6'd31;
    return sum[4:0];
  endfunction

  // End-around-carry addition modulo 127 on 7-bit operands.
  function automatic logic [6:0] add127(logic [6:0] a, logic [6:0] b);
    logic [7:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum > 8'd127) sum = sum - 8'd127;
    return sum[6:0];
  endfunction

  always_comb begin
    mix    = din_q ^ ob_q;
    ri     = mix[4:0];
    si     = {mix[3:0], mix[7:5]};
    ti     = mix[7:3];

    r_rot  = {r_q[6][3:0], r_q[6][4]};
    r_head = add31(r_q[3], r_rot);
    s_rot  = {s_q[6][5:0], s_q[6][6]};
    s_head = add127(s_q[5], s_rot);
    t_head = add31(t_q[4], t_q[2]);

    r_d[6] = r_q[5];
    r_d[5] = r_q[4];
    r_d[4] = r_q[3];
    r_d[3] = r_q[2] ^ ri;
    r_d[2] = r_q[1];
    r_d[1] = r_q[0];
    r_d[0] = r_head;

    s_d[6] = s_q[5];
    s_d[5] = s_q[4] ^ si;
    s_d[4] = s_q[3];
    s_d[3] = s_q[2];
    s_d[2] = s_q[1];
    s_d[1] = s_q[0];
    s_d[0] = s_head;

    t_d[4] = t_q[3];
    t_d[3] = t_q[2];
    t_d[2] = t_q[1] ^ ti;
    t_d[1] = t_q[0];
    t_d[0] = t_head;

    // Output multiplexer on the new cell values: S selects between R and T.
    nib  = (~s_head[3:0] & (r_head[3:0] ^ r_q[3][3:0])) |
           ( s_head[3:0] & (t_head[3:0] ^ t_q[2][3:0]));
    ob_d = {ob_q[3:0], nib};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q  <= '{default: '0};
      s_q  <= '{default: '0};
      t_q  <= '{default: '0};
      ob_q <= '0;
    end else if (cmd_i.clear) begin
      r_q  <= '{default: '0};
      s_q  <= '{default: '0};
      t_q  <= '{default: '0};
      ob_q <= '0;
    end else if (cmd_i.step) begin
      r_q  <= r_d;
      s_q  <= s_d;
      t_q  <= t_d;
      ob_q <= ob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      din_q <= data_in_i;
    end
    if (cmd_i.res_load) begin
      res_q <= ob_q;
    end
  end

  assign ks_byte_o = res_q;

endmodule

// ===== sv/gpa_cipher_keystream_core.sv =====
// GPA keystream core: a user takes one command beat on in_i and gets exactly
// one result beat on out_o. A clock beat (command 0) XORs data_in with the
// running output byte, injects it into the three nonlinear shift registers
// R, S and T, and applies repeat_count cipher steps with the same data byte;
// each step shifts one nibble into the output byte. A clear beat (command 1)
// zeroes all cipher state and reports zero. The result beat carries the
// output byte as it stands after the command. The command is latched at the
// accepting edge itself; the cipher steps then run one after another, since
// each one feeds its output byte back into the next injection, and after the
// last step the output byte moves into the result register. The core takes
// its next command from the same cycle in which the result beat is offered.
// The result register parts the two channels, so a new command is accepted
// while an earlier result still waits to be taken; the core only holds its
// final cycle when that register is still occupied. Depends on gpa_ks_pkg,
// the channel interfaces, the controller and the datapath.
`include "gpa_cipher_keystream_core_macros.svh"

module gpa_cipher_keystream_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpa_ks_in_if.sink     in_i,
  gpa_ks_out_if.source  out_o
);

  // Command bundle from the controller to the datapath.
  gpa_ks_pkg::dp_cmd_t dp_cmd;

  // The controller owns both handshakes and counts the cipher steps.
  gpa_ks_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_count_i   (in_i.repeat_count),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (dp_cmd)
  );

  // The datapath holds the cipher state and the result register.
  gpa_ks_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .data_in_i (in_i.data_in),
    .ks_byte_o (out_o.ks_byte)
  );

  // Once a beat is accepted the core is busy in the cycle after it.
  `GPA_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "ready after accept")
  // A pending result is never overwritten before it is taken.
  `GPA_ASSERT_SAME(a_no_res_overwrite, dp_cmd.res_load, !out_o.valid || out_o.ready, "result overwritten")
  // Stepping and publishing a result only happen while the core is busy.
  `GPA_ASSERT_SAME(a_step_only_busy, dp_cmd.step || dp_cmd.res_load, !in_i.ready, "step while idle")

endmodule

// ===== tb/gpa_ks_checker.sv =====
// Passive checker for the GPA keystream core: watches both channels, predicts each result byte.
// Depends on gpa_ks_pkg and the gpa_ks_in_if / gpa_ks_out_if channel interfaces.
module gpa_ks_checker
  import gpa_ks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gpa_ks_in_if        cmd_mon,
  gpa_ks_out_if       res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [RW-1:0] r_cell [RN];
  logic [SW-1:0] s_cell [SN];
  logic [TW-1:0] t_cell [TN];
  logic [7:0]    out_byte;
  logic [7:0]    byte_due_q [$];

  // End-around-carry sums: a carry past the modulus wraps back in.
  function automatic logic [4:0] add_mod31(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum > 6'd31) sum = sum - 6'd31;
    return sum[4:0];
  endfunction

  function automatic logic [6:0] add_mod127(input logic [6:0] a, input logic [6:0] b);
    logic [7:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum > 8'd127) sum = sum - 8'd127;
    return sum[6:0];
  endfunction

  task automatic clear_cipher();
    int k;
    for (k = 0; k < RN; k++) r_cell[k] = '0;
    for (k = 0; k < SN; k++) s_cell[k] = '0;
    for (k = 0; k < TN; k++) t_cell[k] = '0;
    out_byte = '0;
  endtask

  task automatic cipher_step(input logic [7:0] din);
    logic [7:0] mix;
    logic [4:0] r_in, t_in, r_head, t_head;
    logic [6:0] s_in, s_head;
    logic [3:0] nib;
    mix  = din ^ out_byte;
    r_in = mix[4:0];
    s_in = {mix[3:0], mix[7:5]};
    t_in = mix[7:3];

    // R: tap G rotated left by one before the sum.
    r_head    = add_mod31(r_cell[3], {r_cell[6][3:0], r_cell[6][4]});
    r_cell[6] = r_cell[5];
    r_cell[5] = r_cell[4];
    r_cell[4] = r_cell[3];
    r_cell[3] = r_cell[2] ^ r_in;
    r_cell[2] = r_cell[1];
    r_cell[1] = r_cell[0];
    r_cell[0] = r_head;

    s_head    = add_mod127(s_cell[5], {s_cell[6][5:0], s_cell[6][6]});
    s_cell[6] = s_cell[5];
    s_cell[5] = s_cell[4] ^ s_in;
    s_cell[4] = s_cell[3];
    s_cell[3] = s_cell[2];
    s_cell[2] = s_cell[1];
    s_cell[1] = s_cell[0];
    s_cell[0] = s_head;

    t_head    = add_mod31(t_cell[4], t_cell[2]);
    t_cell[4] = t_cell[3];
    t_cell[3] = t_cell[2];
    t_cell[2] = t_cell[1] ^ t_in;
    t_cell[1] = t_cell[0];
    t_cell[0] = t_head;

    // The new S head selects, bit by bit, between the R and T nibbles.
    nib = (~s_cell[0][3:0] & (r_cell[0][3:0] ^ r_cell[4][3:0])) |
          ( s_cell[0][3:0] & (t_cell[0][3:0] ^ t_cell[3][3:0]));
    out_byte = {out_byte[3:0], nib};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      clear_cipher();
      byte_due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (byte_due_q.size() == 0) begin
          $display("%0t: result beat with none expected: expected none actual %02h",
                   $time, res_mon.ks_byte);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = byte_due_q.pop_front();
          if (res_mon.ks_byte !== want) begin
            $display("%0t: ks_byte mismatch: expected %02h actual %02h",
                     $time, want, res_mon.ks_byte);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (cmd_mon.command == CMD_CLEAR) begin
          clear_cipher();
        end else begin
          repeat (cmd_mon.repeat_count) cipher_step(cmd_mon.data_in);
        end
        byte_due_q.push_back(out_byte);
      end
      pending_o <= byte_due_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the GPA keystream core testbench: clock, reset, command stimulus and verdict.
// Depends on gpa_ks_pkg, the channel interfaces, gpa_cipher_keystream_core and gpa_ks_checker.
module testbench;
  import gpa_ks_pkg::*;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  gpa_ks_in_if  cmd_ch ();
  gpa_ks_out_if res_ch ();

  gpa_cipher_keystream_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  gpa_ks_checker byte_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon      (cmd_ch),
    .res_mon      (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // The result side takes beats or stalls on its own, one decision per cycle.
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offers one command beat, after a random number of idle cycles, and returns at the
  // falling edge after it was taken. Valid stays high so back-to-back beats need no gap.
  task automatic send_cmd(input gpa_cmd_e cmd, input logic [7:0] din,
                          input logic [CNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= cmd;
    cmd_ch.data_in      <= din;
    cmd_ch.repeat_count <= cnt;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly clock beats with random data; the repeat count favors its two ends now and
  // then, and an occasional clear (with junk in the ignored fields) restarts the cipher.
  task automatic send_random_cmd();
    int unsigned pick;
    logic [CNT_W-1:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_cmd(CMD_CLEAR, 8'($urandom), CNT_W'($urandom));
    end else begin
      if (pick < 15) cnt = '0;
      else if (pick < 25) cnt = '1;
      else cnt = CNT_W'($urandom_range(1, 14));
      send_cmd(CMD_CLOCK, 8'($urandom), cnt);
    end
  endtask

  initial begin
    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_CLOCK;
    cmd_ch.data_in      = '0;
    cmd_ch.repeat_count = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: zero repeat from reset and from a busy state, the longest run with
    // all-zero and all-one data, single steps, and clears with the ignored fields set.
    send_cmd(CMD_CLOCK, 8'h00, 4'h0);
    send_cmd(CMD_CLEAR, 8'h00, 4'h0);
    send_cmd(CMD_CLOCK, 8'h00, 4'h1);
    send_cmd(CMD_CLOCK, 8'hff, 4'hf);
    send_cmd(CMD_CLOCK, 8'hff, 4'h0);
    send_cmd(CMD_CLOCK, 8'h00, 4'hf);
    send_cmd(CMD_CLOCK, 8'haa, 4'h5);
    send_cmd(CMD_CLOCK, 8'h55, 4'ha);
    send_cmd(CMD_CLEAR, 8'hff, 4'hf);
    send_cmd(CMD_CLOCK, 8'h80, 4'h1);
    send_cmd(CMD_CLOCK, 8'h01, 4'h2);
    send_cmd(CMD_CLOCK, 8'h0f, 4'h4);
    send_cmd(CMD_CLOCK, 8'hf0, 4'h8);
    send_cmd(CMD_CLEAR, 8'h5a, 4'h7);
    send_cmd(CMD_CLEAR, 8'ha5, 4'h8);
    send_cmd(CMD_CLOCK, 8'hc3, 4'hf);

    // Random part in four flow-control phases: free running, sender gaps, result stalls,
    // and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      repeat (210) send_random_cmd();
    end

    cmd_ch.valid  <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Give any stray result beat time to show up.
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
